// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the wavelet threshold RTL.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge out of reset.
`define WCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// A consequence that must hold in the same cycle as its trigger.
`define WCT_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

`endif

// ===== hdl/wct_pkg.sv =====
// Shared types and constants for the wavelet coefficient threshold block.
// Used by the controller, the datapath and the top level; no dependencies.
package wct_pkg;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_W = 1;
  localparam int unsigned MODE_W     = 2;
  localparam int unsigned THRESH_W   = 31;

  localparam logic [CFG_ADDR_W-1:0] CFG_MODE      = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 1'b1;

  // Thresholding modes; the unused code behaves as hard mode.
  localparam logic [MODE_W-1:0] MODE_HARD  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SOFT  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FUZZY = 2'd2;

  // Offset added before the soft magnitude, 0.0001 in Q15.16.
  localparam int unsigned EPS_LSB = 7;
  // Nonzero values a window needs to keep its center value in fuzzy mode.
  localparam int unsigned MIN_NEIGHBORS = 5;
  // Width of the whole-quotient count from the pre-reduction (at most 8).
  localparam int unsigned QC_W = 4;

  // Source of the value written into the lookahead buffer.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RAW,
    SRC_SOFT
  } src_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic prep;
    logic div_init;
    logic reduce_step;
    logic div_step;
    logic append;
    src_e src;
    logic emit;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic soft_mode;
    logic a_gt_t;
    logic mag_gt_t;
    logic rem_ge_a;
    logic div_last;
    logic last;
    logic fill_full;
    logic fill_one;
    logic out_free;
  } status_t;

endpackage

// ===== hdl/wavelet_coefficient_threshold_top.sv =====
// Wavelet coefficient threshold block: hard, soft and fuzzy-pruned modes.
// Instantiates wct_ctrl and wct_datapath; depends on wct_pkg.
//
// Usage:
//   Input words arrive on the s_axis channel (signed Q15.16 sample in tdata,
//   tlast on the final coefficient of a block). Thresholded words leave on
//   the m_axis channel in input order, tlast on the final word of a block.
//   Mode and threshold are written through the cfg port while the block is
//   idle; index 0 is the mode, index 1 the threshold.
//   Values wait in a lookahead of WINDOW_HALF words, so the first output of
//   a block appears after WINDOW_HALF inputs; tlast on input flushes every
//   waiting word, one per cycle while the receiver takes them.
//   One word is taken at a time. Hard mode, and a soft or fuzzy word whose
//   value thresholds to zero, pass through load, check, decide and post
//   steps. Other soft and fuzzy words add a pre-reduction, then the radix-2
//   multiply-divide unit that handles one bit of the scaled difference per
//   cycle, then an append step. Each emitted word adds an emit step.
//   A result waits in an output register, so a stalled receiver holds only
//   the emitting step; the next input word is still taken meanwhile.
//   Reset clears mode, threshold, lookahead and history to zero.
module wavelet_coefficient_threshold_top
  import wct_pkg::*;
#(
  parameter int unsigned WINDOW_HALF = 5,
  parameter int unsigned SAMPLE_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]                 cfg_index_i,
  input  logic [THRESH_W-1:0]                   cfg_data_i,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  // tdata: sample, then zero fill up to whole bytes.
  input  logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // tdata: result_sample, then zero fill up to whole bytes.
  output logic [((SAMPLE_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
  output logic                                  m_axis_tlast
);

  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

  cmd_t                   cmd;
  status_t                st;
  logic [SAMPLE_BITS-1:0] out_sample;

  wct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  wct_datapath #(
    .WH (WINDOW_HALF),
    .SB (SAMPLE_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_sample_i  (s_axis_tdata[SAMPLE_BITS-1:0]),
    .in_last_i    (s_axis_tlast),
    .cmd_i        (cmd),
    .st_o         (st),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (out_sample),
    .out_last_o   (m_axis_tlast)
  );

  // Zero-fill the result up to the byte-aligned bus width.
  assign m_axis_tdata = DATA_W'(out_sample);

endmodule

// ===== hdl/wct_ctrl.sv =====
// Controller state machine for the wavelet coefficient threshold block.
// Depends on wct_pkg for the command and status structs.
module wct_ctrl
  import wct_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t st_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_REDUCE = 3'd3;
  localparam logic [2:0] S_ITER   = 3'd4;
  localparam logic [2:0] S_APPEND = 3'd5;
  localparam logic [2:0] S_POST   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;

  // Next state and command decode.
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    cmd_o.src  = SRC_ZERO;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.prep = 1'b1;
        state_d    = S_DECIDE;
      end
      S_DECIDE: begin
        if (st_i.soft_mode && st_i.a_gt_t) begin
          cmd_o.div_init = 1'b1;
          state_d        = S_REDUCE;
        end else begin
          cmd_o.append = 1'b1;
          cmd_o.src    = (!st_i.soft_mode && st_i.mag_gt_t) ? SRC_RAW : SRC_ZERO;
          state_d      = S_POST;
        end
      end
      S_REDUCE: begin
        if (st_i.rem_ge_a) begin
          cmd_o.reduce_step = 1'b1;
        end else begin
          state_d = S_ITER;
        end
      end
      S_ITER: begin
        cmd_o.div_step = 1'b1;
        if (st_i.div_last) begin
          state_d = S_APPEND;
        end
      end
      S_APPEND: begin
        cmd_o.append = 1'b1;
        cmd_o.src    = SRC_SOFT;
        state_d      = S_POST;
      end
      S_POST: begin
        state_d = (st_i.last || st_i.fill_full) ? S_EMIT : S_IDLE;
      end
      S_EMIT: begin
        if (st_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!st_i.last || st_i.fill_one) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== hdl/wct_datapath.sv =====
// Datapath of the wavelet coefficient threshold block: configuration,
// soft-threshold multiply-divide unit, lookahead window and output register.
// Depends on wct_pkg and assert_macros.svh.
`include "assert_macros.svh"
module wct_datapath
  import wct_pkg::*;
#(
  parameter int unsigned WH = 5,
  parameter int unsigned SB = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_ADDR_W-1:0] cfg_index_i,
  input  logic [THRESH_W-1:0]   cfg_data_i,
  input  logic [SB-1:0]         in_sample_i,
  input  logic                  in_last_i,
  input  cmd_t                  cmd_i,
  output status_t               st_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [SB-1:0]         out_sample_o,
  output logic                  out_last_o
);

  localparam int unsigned CW   = (SB > THRESH_W) ? SB : THRESH_W;
  localparam int unsigned BC_W = $clog2(SB);
  localparam int unsigned FW   = $clog2(WH + 1);
  localparam int unsigned NW   = $clog2(2 * WH + 1);

  logic [MODE_W-1:0]   mode_q;
  logic [THRESH_W-1:0] thresh_q;
  logic [SB-1:0]       x_q;
  logic                last_q;
  logic [SB-1:0]       a_q, mag_q;
  logic [SB-1:0]       rm_q, r_q, d_q, q_q;
  logic [QC_W-1:0]     c_q;
  logic [BC_W-1:0]     bit_cnt_q;
  logic [SB-1:0]       la_q [WH];
  logic [SB-1:0]       hist_q [WH];
  logic [SB-1:0]       la_d [WH];
  logic [SB-1:0]       hist_d [WH];
  logic [FW-1:0]       fill_q, fill_d;
  logic                out_valid_q, out_last_q;
  logic [SB-1:0]       out_data_q;
  logic                out_free;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_HARD;
      thresh_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MODE:      mode_q   <= cfg_data_i[MODE_W-1:0];
        CFG_THRESHOLD: thresh_q <= cfg_data_i;
        default:       ;
      endcase
    end
  end

  // Magnitudes of the sample and of the sample plus the offset.
  logic signed [SB:0] y_ext;
  logic [SB-1:0]      a_d, mag_d;
  always_comb begin
    y_ext = $signed({x_q[SB-1], x_q}) + $signed((SB + 1)'(EPS_LSB));
    a_d   = y_ext[SB] ? SB'(-y_ext) : y_ext[SB-1:0];
    mag_d = x_q[SB-1] ? (SB'(0) - x_q) : x_q;
  end

  // One step of the interleaved multiply-divide: q,r track m*d_prefix / a.
  logic [SB:0]   r2, r3, s_sum, r_next;
  logic          ge1, ge2;
  logic [SB-1:0] q_shift, q_next;
  always_comb begin
    r2      = {r_q, 1'b0};
    ge1     = r2 >= {1'b0, a_q};
    r3      = ge1 ? (r2 - {1'b0, a_q}) : r2;
    q_shift = {q_q[SB-2:0], ge1};
    s_sum   = r3 + {1'b0, rm_q};
    ge2     = s_sum >= {1'b0, a_q};
    r_next  = r3;
    q_next  = q_shift;
    if (d_q[SB-1]) begin
      r_next = ge2 ? (s_sum - {1'b0, a_q}) : s_sum;
      q_next = q_shift + SB'(c_q) + SB'(ge2);
    end
  end

  // Sample capture and soft-threshold arithmetic registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= 1'b0;
    end else if (cmd_i.load) begin
      last_q <= in_last_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= in_sample_i;
    end
    if (cmd_i.prep) begin
      a_q   <= a_d;
      mag_q <= mag_d;
    end
    if (cmd_i.div_init) begin
      d_q       <= SB'(CW'(a_q) - CW'(thresh_q));
      rm_q      <= mag_q;
      c_q       <= '0;
      q_q       <= '0;
      r_q       <= '0;
      bit_cnt_q <= BC_W'(SB - 1);
    end else if (cmd_i.reduce_step) begin
      rm_q <= rm_q - a_q;
      c_q  <= c_q + QC_W'(1);
    end else if (cmd_i.div_step) begin
      r_q       <= r_next[SB-1:0];
      q_q       <= q_next;
      d_q       <= {d_q[SB-2:0], 1'b0};
      bit_cnt_q <= bit_cnt_q - BC_W'(1);
    end
  end

  // Value entering the lookahead buffer.
  logic [SB-1:0] new_val;
  always_comb begin
    case (cmd_i.src)
      SRC_RAW:  new_val = x_q;
      SRC_SOFT: new_val = x_q[SB-1] ? (SB'(0) - q_q) : q_q;
      default:  new_val = '0;
    endcase
  end

  // Count nonzero values in the history and the lookahead buffer.
  logic [NW-1:0] nz_count;
  always_comb begin
    nz_count = '0;
    for (int k = 0; k < WH; k++) begin
      nz_count = nz_count + NW'(hist_q[k] != '0) + NW'(la_q[k] != '0);
    end
  end

  // Oldest value, pruned in fuzzy mode when its window is too sparse.
  logic [SB-1:0] emit_val;
  logic          fill_one;
  always_comb begin
    emit_val = la_q[0];
    if (mode_q == MODE_FUZZY && la_q[0] != '0 && 32'(nz_count) < 32'(MIN_NEIGHBORS)) begin
      emit_val = '0;
    end
    fill_one = fill_q == FW'(1);
  end

  // Lookahead and history update.
  always_comb begin
    la_d   = la_q;
    hist_d = hist_q;
    fill_d = fill_q;
    if (cmd_i.append) begin
      for (int k = 0; k < WH; k++) begin
        if (fill_q == FW'(k)) begin
          la_d[k] = new_val;
        end
      end
      fill_d = fill_q + FW'(1);
    end else if (cmd_i.emit) begin
      if (last_q && fill_one) begin
        for (int k = 0; k < WH; k++) begin
          la_d[k]   = '0;
          hist_d[k] = '0;
        end
        fill_d = '0;
      end else begin
        for (int k = 0; k + 1 < WH; k++) begin
          la_d[k]   = la_q[k+1];
          hist_d[k] = hist_q[k+1];
        end
        la_d[WH-1]   = '0;
        hist_d[WH-1] = emit_val;
        fill_d       = fill_q - FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WH; k++) begin
        la_q[k]   <= '0;
        hist_q[k] <= '0;
      end
      fill_q <= '0;
    end else begin
      la_q   <= la_d;
      hist_q <= hist_d;
      fill_q <= fill_d;
    end
  end

  // Output register; a waiting word does not block the input side.
  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
      out_last_q  <= last_q && fill_one;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= emit_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_data_q;
  assign out_last_o   = out_last_q;

  // Status back to the controller.
  always_comb begin
    st_o.soft_mode = mode_q inside {MODE_SOFT, MODE_FUZZY};
    st_o.a_gt_t    = CW'(a_q) > CW'(thresh_q);
    st_o.mag_gt_t  = CW'(mag_q) > CW'(thresh_q);
    st_o.rem_ge_a  = rm_q >= a_q;
    st_o.div_last  = bit_cnt_q == '0;
    st_o.last      = last_q;
    st_o.fill_full = fill_q == FW'(WH);
    st_o.fill_one  = fill_one;
    st_o.out_free  = out_free;
  end

  `WCT_ASSERT_IMPL(a_emit_free, cmd_i.emit, out_free, "emit would overwrite a waiting word")
  `WCT_ASSERT(a_fill_range, fill_q <= FW'(WH), "lookahead fill count out of range")
  `WCT_ASSERT_IMPL(a_soft_bound, cmd_i.append && cmd_i.src == SRC_SOFT, q_q <= mag_q, "soft magnitude exceeds input magnitude")

endmodule
